// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the websocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

  // Queue depth between parser and emitter
  localparam int unsigned QDepthDef = 4;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_DELIVER_TEXT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELIVER_BINARY = 2'd1;

  // Frame opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Result kinds
  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_CLOSE  = 2'd2;

  // Close reply bytes
  localparam logic [7:0] CLOSE_BYTE0 = 8'h88;
  localparam logic [7:0] CLOSE_BYTE1 = 8'h00;

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_CLOSE = 1'b1
  } act_e;

  // One queued action: a single data result or a close reply pair
  typedef struct packed {
    act_e       act;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       empty;
  } wsd_entry_t;

endpackage

// ===== hw/rtl/wsd_front.sv =====
// Frame parser: walks header, length, mask key and payload, queues actions.
`timescale 1ns / 1ps
module wsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              deliver_text_i,
  input  logic              deliver_binary_i,
  output logic              push_o,
  output wsd_pkg::wsd_entry_t entry_o
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_cnt_q, key_cnt_d;
  logic [1:0]  rot_q, rot_d;

  logic       data_en;
  logic [1:0] data_kind;
  logic [7:0] key_byte;
  logic       last;

  assign data_en   = (opcode_q == OP_TEXT && deliver_text_i) ||
                     (opcode_q == OP_BINARY && deliver_binary_i);
  assign data_kind = (opcode_q == OP_TEXT) ? KIND_TEXT : KIND_BINARY;
  // rotation 0 selects the first key byte in bits 31..24
  assign key_byte  = key_q[{~rot_q, 3'b000} +: 8];
  assign last      = (len_q == 64'd1);

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    ext_cnt_d = ext_cnt_q;
    len_d     = len_q;
    key_d     = key_q;
    key_cnt_d = key_cnt_q;
    rot_d     = rot_q;
    push_o    = 1'b0;
    entry_o   = '{act: ACT_DATA, kind: data_kind, data: 8'h00, last: 1'b0, empty: 1'b0};
    if (accept_i) begin
      case (phase_q)
        PH_LEN: begin
          key_d     = '0;
          key_cnt_d = '0;
          if (in_byte_i[6:0] == LEN_EXT16) begin
            len_d     = '0;
            ext_cnt_d = 3'd1;
            phase_d   = PH_EXT;
          end else if (in_byte_i[6:0] == LEN_EXT64) begin
            len_d     = '0;
            ext_cnt_d = 3'd7;
            phase_d   = PH_EXT;
          end else begin
            len_d   = {57'd0, in_byte_i[6:0]};
            phase_d = PH_MASK;
          end
        end
        PH_EXT: begin
          len_d = {len_q[55:0], in_byte_i};
          if (ext_cnt_q == 3'd0) begin
            phase_d = PH_MASK;
          end else begin
            ext_cnt_d = ext_cnt_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], in_byte_i};
          if (key_cnt_q == 2'd3) begin
            key_cnt_d = '0;
            rot_d     = '0;
            if (len_q == 64'd0) begin
              // zero-length frame completes on the last key byte
              if (data_en) begin
                push_o        = 1'b1;
                entry_o.last  = 1'b1;
                entry_o.empty = 1'b1;
              end else if (opcode_q == OP_CLOSE) begin
                push_o      = 1'b1;
                entry_o.act = ACT_CLOSE;
              end
              phase_d = PH_HDR0;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            key_cnt_d = key_cnt_q + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          rot_d = rot_q + 2'd1;
          len_d = len_q - 64'd1;
          if (data_en) begin
            push_o       = 1'b1;
            entry_o.data = in_byte_i ^ key_byte;
            entry_o.last = last;
          end else if (last && opcode_q == OP_CLOSE) begin
            push_o      = 1'b1;
            entry_o.act = ACT_CLOSE;
          end
          if (last) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          opcode_d = in_byte_i[3:0];
          phase_d  = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      opcode_q  <= '0;
      ext_cnt_q <= '0;
      len_q     <= '0;
      key_q     <= '0;
      key_cnt_q <= '0;
      rot_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      ext_cnt_q <= ext_cnt_d;
      len_q     <= len_d;
      key_q     <= key_d;
      key_cnt_q <= key_cnt_d;
      rot_q     <= rot_d;
    end
  end

endmodule

// ===== hw/rtl/wsd_fifo.sv =====
// Action queue between the parser and the result emitter.
`timescale 1ns / 1ps
module wsd_fifo #(
  parameter int unsigned Depth = wsd_pkg::QDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsd_pkg::wsd_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output wsd_pkg::wsd_entry_t rd_data_o
);
  import wsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  wsd_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/wsd_back.sv =====
// Result emitter: drains queued actions into the output register.
`timescale 1ns / 1ps
module wsd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  wsd_pkg::wsd_entry_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          out_kind_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_of_run_o,
  output logic                out_empty_frame_o
);
  import wsd_pkg::*;

  logic       valid_q;
  logic       pend_close_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       empty_q;
  logic       free;

  // output register can take a new result this cycle
  assign free    = !valid_q || !out_stall_i;
  assign q_pop_o = free && !pend_close_q && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      pend_close_q <= 1'b0;
      kind_q       <= '0;
      byte_q       <= '0;
      last_q       <= 1'b0;
      empty_q      <= 1'b0;
    end else if (free) begin
      if (pend_close_q) begin
        // second byte of the close reply
        valid_q      <= 1'b1;
        pend_close_q <= 1'b0;
        kind_q       <= KIND_CLOSE;
        byte_q       <= CLOSE_BYTE1;
        last_q       <= 1'b1;
        empty_q      <= 1'b0;
      end else if (!q_empty_i) begin
        valid_q <= 1'b1;
        if (q_data_i.act == ACT_CLOSE) begin
          pend_close_q <= 1'b1;
          kind_q       <= KIND_CLOSE;
          byte_q       <= CLOSE_BYTE0;
          last_q       <= 1'b0;
          empty_q      <= 1'b0;
        end else begin
          kind_q  <= q_data_i.kind;
          byte_q  <= q_data_i.data;
          last_q  <= q_data_i.last;
          empty_q <= q_data_i.empty;
        end
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = valid_q;
  assign out_kind_o        = kind_q;
  assign out_byte_o        = byte_q;
  assign out_last_of_run_o = last_q;
  assign out_empty_frame_o = empty_q;

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level of the websocket frame deframer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_byte
//   out      output     out_valid/out_stall  out_kind, out_byte, out_last_of_run,
//                                            out_empty_frame
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle unless the action queue is full; the parser state
// advances on every accepted byte. A byte's result passes through the action queue
// and then the output register. A close reply is two output bytes, paced by the
// output register. Input stalls only when the action queue (QDepth entries) is full.
// Reset puts the parser at the first header byte with both delivery enables set.
`timescale 1ns / 1ps
module websocket_frame_deframer #(
  parameter int unsigned QDepth = wsd_pkg::QDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  out_kind_o,
  output logic [7:0]                  out_byte_o,
  output logic                        out_last_of_run_o,
  output logic                        out_empty_frame_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wsd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                        cfg_data_i
);
  import wsd_pkg::*;

  logic       deliver_text_q;
  logic       deliver_binary_q;
  logic       accept;
  logic       push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  wsd_entry_t push_entry;
  wsd_entry_t q_entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deliver_text_q   <= 1'b1;
      deliver_binary_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DELIVER_TEXT:   deliver_text_q   <= cfg_data_i;
        CFG_DELIVER_BINARY: deliver_binary_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wsd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .in_byte_i        (in_byte_i),
    .deliver_text_i   (deliver_text_q),
    .deliver_binary_i (deliver_binary_q),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  wsd_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .rd_data_o   (q_entry)
  );

  wsd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_entry),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .out_byte_o        (out_byte_o),
    .out_last_of_run_o (out_last_of_run_o),
    .out_empty_frame_o (out_empty_frame_o)
  );

endmodule

// ===== test/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for the websocket frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxReports   = 100;

  // Indexes past the two registers; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [3:0] OP_CONT = 4'h0;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_e;

  typedef enum int {
    LEN_SHORT,
    LEN_16,
    LEN_64
  } len_form_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       empty;
  } deframe_out_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         in_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         out_kind_o;
  logic [7:0]         out_byte_o;
  logic               out_last_of_run_o;
  logic               out_empty_frame_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic               cfg_data_i  = 1'b0;

  // Predictor copy of registers and parser state
  logic        dlv_text     = 1'b1;
  logic        dlv_binary   = 1'b1;
  phase_e      pr_phase     = PH_HEADER;
  logic [3:0]  pr_opcode    = '0;
  logic [2:0]  pr_ext_left  = '0;
  logic [63:0] pr_length    = '0;
  logic [31:0] pr_key       = '0;
  logic [1:0]  pr_key_count = '0;
  logic [63:0] pr_remaining = '0;
  logic [1:0]  pr_rotation  = '0;

  deframe_out_t pending_out[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int frames_sent   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int cycles        = 0;

  websocket_frame_deframer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .out_byte_o        (out_byte_o),
    .out_last_of_run_o (out_last_of_run_o),
    .out_empty_frame_o (out_empty_frame_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_out.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- prediction ----------------

  function automatic bit data_delivered();
    return (pr_opcode == OP_TEXT && dlv_text) || (pr_opcode == OP_BINARY && dlv_binary);
  endfunction

  task automatic push_result(logic [1:0] kind, logic [7:0] data, logic last, logic empty);
    pending_out.push_back('{kind, data, last, empty});
  endtask

  task automatic push_close_reply();
    push_result(KIND_CLOSE, CLOSE_BYTE0, 1'b0, 1'b0);
    push_result(KIND_CLOSE, CLOSE_BYTE1, 1'b1, 1'b0);
  endtask

  task automatic predict_byte(logic [7:0] b);
    logic [7:0] key_byte;
    logic [1:0] data_kind;
    logic       last;
    data_kind = (pr_opcode == OP_TEXT) ? KIND_TEXT : KIND_BINARY;
    case (pr_phase)
      PH_LENGTH: begin
        pr_length    = '0;
        pr_key       = '0;
        pr_key_count = '0;
        if (b[6:0] == LEN_EXT16) begin
          pr_ext_left = 3'd1;
          pr_phase    = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          pr_ext_left = 3'd7;
          pr_phase    = PH_EXTLEN;
        end else begin
          pr_length = 64'(b[6:0]);
          pr_phase  = PH_KEY;
        end
      end
      PH_EXTLEN: begin
        pr_length = {pr_length[55:0], b};
        if (pr_ext_left == 3'd0) pr_phase = PH_KEY;
        else pr_ext_left = pr_ext_left - 3'd1;
      end
      PH_KEY: begin
        pr_key = {pr_key[23:0], b};
        if (pr_key_count == 2'd3) begin
          pr_key_count = '0;
          pr_rotation  = '0;
          pr_remaining = pr_length;
          if (pr_remaining == 64'd0) begin
            if (data_delivered()) push_result(data_kind, 8'h00, 1'b1, 1'b1);
            else if (pr_opcode == OP_CLOSE) push_close_reply();
            pr_phase = PH_HEADER;
          end else begin
            pr_phase = PH_PAYLOAD;
          end
        end else begin
          pr_key_count = pr_key_count + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        key_byte     = pr_key[8*(3-int'(pr_rotation)) +: 8];
        pr_rotation  = pr_rotation + 2'd1;
        pr_remaining = pr_remaining - 64'd1;
        last         = (pr_remaining == 64'd0);
        if (data_delivered()) push_result(data_kind, b ^ key_byte, last, 1'b0);
        if (last) begin
          if (pr_opcode == OP_CLOSE) push_close_reply();
          pr_phase = PH_HEADER;
        end
      end
      default: begin
        pr_opcode = b[3:0];
        pr_phase  = PH_LENGTH;
      end
    endcase
  endtask

  // ---------------- checking ----------------

  always @(posedge clk_i) begin
    deframe_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result: kind %0d byte %02h last %0b empty %0b", $time,
                   out_kind_o, out_byte_o, out_last_of_run_o, out_empty_frame_o);
      end else begin
        want = pending_out.pop_front();
        if (want.kind !== out_kind_o || want.data !== out_byte_o ||
            want.last !== out_last_of_run_o || want.empty !== out_empty_frame_o) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: mismatch: expected %0d/%02h/%0b/%0b, got %0d/%02h/%0b/%0b",
                     $time, want.kind, want.data, want.last, want.empty,
                     out_kind_o, out_byte_o, out_last_of_run_o, out_empty_frame_o);
        end
      end
    end
  end

  // ---------------- driving ----------------

  function automatic bit sender_idles();
    return $urandom_range(99) < in_idle_pct;
  endfunction

  // Called and returns at a falling edge
  task automatic send_byte(logic [7:0] b);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b);
    items_sent++;
    @(negedge clk_i);
    if (sender_idles()) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (sender_idles());
    end
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_DELIVER_TEXT) dlv_text = val;
    else if (idx == CFG_DELIVER_BINARY) dlv_binary = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Header, length in the given form, random key; FIN/RSV and mask bits random
  task automatic send_frame_head(logic [3:0] opcode, logic [63:0] len, len_form_e form);
    logic [31:0] key;
    key = $urandom;
    send_byte({4'($urandom), opcode});
    case (form)
      LEN_16: begin
        send_byte({1'($urandom), LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      LEN_64: begin
        send_byte({1'($urandom), LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: send_byte({1'($urandom), len[6:0]});
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    frames_sent++;
  endtask

  task automatic send_payload(int count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    int          pick;
    logic [3:0]  opcode;
    logic [63:0] len;
    len_form_e   form;
    pick = $urandom_range(99);
    if (pick < 35) opcode = OP_TEXT;
    else if (pick < 65) opcode = OP_BINARY;
    else if (pick < 78) opcode = OP_CLOSE;
    else opcode = 4'($urandom);
    pick = $urandom_range(99);
    form = LEN_SHORT;
    if (pick < 30) len = 64'($urandom_range(3));
    else if (pick < 75) len = 64'($urandom_range(40, 4));
    else if (pick < 88) len = 64'($urandom_range(125, 41));
    else begin
      // extended forms carrying short lengths
      len  = 64'($urandom_range(160));
      form = (pick < 94) ? LEN_16 : LEN_64;
    end
    send_frame_head(opcode, len, form);
    send_payload(int'(len));
  endtask

  // ---------------- tests ----------------

  task automatic test_basic_frames();
    // text, two bytes, FIN and mask bits set, byte extremes in key and payload
    send_byte({4'h8, OP_TEXT});
    send_byte({1'b1, 7'd2});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'hFF);
    frames_sent++;
    send_frame_head(OP_BINARY, 64'd0, LEN_SHORT);
    // close with payload: payload dropped, reply right after last byte
    send_frame_head(OP_CLOSE, 64'd1, LEN_SHORT);
    send_payload(1);
    send_frame_head(OP_CLOSE, 64'd0, LEN_SHORT);
    drain_outputs();
  endtask

  task automatic test_extended_lengths();
    send_frame_head(OP_TEXT, 64'd3, LEN_16);
    send_payload(3);
    send_frame_head(OP_BINARY, 64'd5, LEN_64);
    send_payload(5);
    send_frame_head(OP_CLOSE, 64'd0, LEN_16);
    send_frame_head(OP_BINARY, 64'd0, LEN_64);
    send_frame_head(OP_CONT, 64'd9, LEN_SHORT);
    send_payload(9);
    send_frame_head(OP_TEXT, 64'd300, LEN_16);
    send_payload(300);
    drain_outputs();
  endtask

  task automatic test_delivery_regs();
    // enable toggled mid-frame; only bytes seen while enabled come out
    send_frame_head(OP_TEXT, 64'd8, LEN_SHORT);
    send_payload(3);
    drain_outputs();
    write_reg(CFG_DELIVER_TEXT, 1'b0);
    send_payload(3);
    drain_outputs();
    write_reg(CFG_DELIVER_TEXT, 1'b1);
    send_payload(2);
    drain_outputs();
    write_reg(CFG_SPARE_A, 1'b0);
    write_reg(CFG_SPARE_B, 1'b0);
    write_reg(CFG_DELIVER_BINARY, 1'b0);
    send_frame_head(OP_BINARY, 64'd0, LEN_SHORT);
    send_frame_head(OP_BINARY, 64'd4, LEN_SHORT);
    send_payload(4);
    send_frame_head(OP_TEXT, 64'd0, LEN_SHORT);
    send_frame_head(OP_CLOSE, 64'd2, LEN_SHORT);
    send_payload(2);
    drain_outputs();
    write_reg(CFG_DELIVER_BINARY, 1'b1);
  endtask

  task automatic test_random_traffic(int idle_in, int idle_out, logic text_on, logic bin_on,
                                     int target);
    int start;
    write_reg(CFG_DELIVER_TEXT, text_on);
    write_reg(CFG_DELIVER_BINARY, bin_on);
    in_idle_pct   = idle_in;
    out_stall_pct = idle_out;
    start         = items_sent;
    while (items_sent - start < target) begin
      send_random_frame();
      if ($urandom_range(29) == 0) drain_outputs();
    end
    drain_outputs();
  endtask

  // Top bit of a 64-bit length set; the frame never completes, so this goes last
  task automatic test_huge_length();
    write_reg(CFG_DELIVER_TEXT, 1'b1);
    write_reg(CFG_DELIVER_BINARY, 1'b1);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_frame_head(OP_TEXT, {32'($urandom) | 32'h8000_0000, 32'($urandom)}, LEN_64);
    send_payload(150);
    drain_outputs();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_frames();
    test_extended_lengths();
    test_delivery_regs();
    test_random_traffic(0, 0, 1'b1, 1'b1, 170);
    test_random_traffic(64, 0, 1'b0, 1'b0, 170);
    test_random_traffic(0, 64, 1'b1, 1'b0, 170);
    test_random_traffic(35, 35, 1'b0, 1'b1, 170);
    test_huge_length();
    $display("Sent %0d bytes in %0d frames, checked %0d results, %0d mismatches",
             items_sent, frames_sent, results_seen, mismatches);
    $display("Covered short/16/64-bit lengths, empty and close frames, enable changes, stalls");
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== websocket_frame_deframer.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_fifo.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer.sv
test/tb_websocket_frame_deframer.sv
